// ----- rtl/envelope_point_interpolator_macros.svh -----
// ----------------------------------------------------------------------------
// Envelope point interpolator assertion macros
// Concurrent assertion forms for the datapath RTL.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_POINT_INTERPOLATOR_MACROS_SVH
`define ENVELOPE_POINT_INTERPOLATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define EPI_ASSERT_IMPLY(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define EPI_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/epi_pkg.sv -----
// ----------------------------------------------------------------------------
// epi_pkg
// Types, codes and constant tables of the envelope point interpolator.
// ----------------------------------------------------------------------------
package epi_pkg;

  localparam int MAX_POINTS_DEF = 64;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_TRUNC  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DEC  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_EXP  = 2'd0,
    CFG_DFLT = 2'd1,
    CFG_STEP = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SK_EVAL  = 2'd0,
    SK_FIRST = 2'd1,
    SK_AFTER = 2'd2
  } srch_kind_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_SR_INIT, OP_SR_RD, OP_SR_CMP, OP_EV_RDA, OP_EV_CAPA,
    OP_EV_CAPB, OP_EV_CLS, OP_LOG_INIT, OP_LOG_STEP, OP_LOG_DONE, OP_MUL1,
    OP_MUL2, OP_MUL3, OP_DIV_INIT, OP_DIV_STEP, OP_RES_QUO, OP_EXP_INIT,
    OP_EXP_STEP, OP_EXP_FIN, OP_RES_DFLT, OP_TR_FIRST, OP_TR_AFTER, OP_TR_CUT,
    OP_AP_RD, OP_AP_C1, OP_AP_C2, OP_AP_DO, OP_FIN
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_AP_RD, S_AP_C1, S_AP_C2, S_AP_DO, S_EV_START, S_SR_RD,
    S_SR_CMP, S_EV_RDA, S_EV_CAPA, S_EV_CAPB, S_EV_CLS, S_LOG_INIT, S_LOG_STEP,
    S_LOG_DONE, S_MUL1, S_MUL2, S_MUL3, S_DIV_INIT, S_DIV_STEP, S_DIV_END,
    S_EXP_STEP, S_EXP_FIN, S_EV_END, S_TR_START, S_TR_FIRST, S_TR_AFTER,
    S_TR_CUT, S_FIN
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    srch_kind_t smode;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic cnt_zero;
    logic srch_done;
    logic endpt;
    logic exp_mode;
    logic cls_hit;
    logic it24_last;
    logic it30_last;
    logic need_now;
    logic need;
  } dp_stat_t;

  typedef logic [31:0] exp_tab_t [24];

  // factors 2^(2^-k), k = 1..24, each the floor Q30 square root of the last
  function automatic exp_tab_t exp_tab_gen();
    exp_tab_t   tab;
    logic [63:0] r;
    logic [63:0] n;
    logic [63:0] res;
    logic [63:0] bv;
    r = 64'd2 << 30;
    for (int k = 0; k < 24; k++) begin
      n   = r << 30;
      res = 64'd0;
      for (int j = 31; j >= 0; j--) begin
        bv = 64'd1 << (2 * j);
        if (n >= res + bv) begin
          n   = n - (res + bv);
          res = (res >> 1) + bv;
        end else begin
          res = res >> 1;
        end
      end
      r      = res;
      tab[k] = r[31:0];
    end
    return tab;
  endfunction

  function automatic logic [23:0] sat24(input logic [31:0] v);
    return (v > 32'h00FF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

endpackage

// ----- rtl/epi_ram.sv -----
// ----------------------------------------------------------------------------
// epi_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module epi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ----- rtl/epi_ctrl.sv -----
// ----------------------------------------------------------------------------
// epi_ctrl
// Sequencer: steps the datapath through append, evaluate and truncate.
// ----------------------------------------------------------------------------
module epi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output epi_pkg::dp_ctl_t  ctl,
  input  epi_pkg::dp_stat_t stat
);

  epi_pkg::state_t     state_r, state_nxt;
  epi_pkg::srch_kind_t srch_r, srch_nxt;
  logic                log2nd_r, log2nd_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= epi_pkg::S_IDLE;
      srch_r   <= epi_pkg::SK_EVAL;
      log2nd_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      srch_r   <= srch_nxt;
      log2nd_r <= log2nd_nxt;
    end
  end

  assign busy = (state_r != epi_pkg::S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    srch_nxt   = srch_r;
    log2nd_nxt = log2nd_r;
    ctl.op     = epi_pkg::OP_NOP;
    ctl.smode  = srch_r;
    unique case (state_r)
      epi_pkg::S_IDLE: begin
        if (start) begin
          ctl.op    = epi_pkg::OP_LOAD;
          state_nxt = epi_pkg::S_DISP;
        end
      end
      epi_pkg::S_DISP: begin
        unique case (stat.cmd)
          epi_pkg::CMD_APPEND: state_nxt = epi_pkg::S_AP_RD;
          epi_pkg::CMD_EVAL:   state_nxt = epi_pkg::S_EV_START;
          epi_pkg::CMD_TRUNC:  state_nxt = epi_pkg::S_TR_START;
          default:             state_nxt = epi_pkg::S_FIN;
        endcase
      end
      epi_pkg::S_AP_RD: begin
        ctl.op    = epi_pkg::OP_AP_RD;
        state_nxt = epi_pkg::S_AP_C1;
      end
      epi_pkg::S_AP_C1: begin
        ctl.op    = epi_pkg::OP_AP_C1;
        state_nxt = epi_pkg::S_AP_C2;
      end
      epi_pkg::S_AP_C2: begin
        ctl.op    = epi_pkg::OP_AP_C2;
        state_nxt = epi_pkg::S_AP_DO;
      end
      epi_pkg::S_AP_DO: begin
        ctl.op    = epi_pkg::OP_AP_DO;
        state_nxt = epi_pkg::S_FIN;
      end
      epi_pkg::S_EV_START: begin
        if (stat.cnt_zero) begin
          ctl.op    = epi_pkg::OP_RES_DFLT;
          state_nxt = epi_pkg::S_EV_END;
        end else begin
          ctl.op    = epi_pkg::OP_SR_INIT;
          ctl.smode = epi_pkg::SK_EVAL;
          srch_nxt  = epi_pkg::SK_EVAL;
          state_nxt = epi_pkg::S_SR_RD;
        end
      end
      epi_pkg::S_SR_RD: begin
        if (stat.srch_done) begin
          unique case (srch_r)
            epi_pkg::SK_FIRST: state_nxt = epi_pkg::S_TR_FIRST;
            epi_pkg::SK_AFTER: state_nxt = epi_pkg::S_TR_AFTER;
            default:           state_nxt = epi_pkg::S_EV_RDA;
          endcase
        end else begin
          ctl.op    = epi_pkg::OP_SR_RD;
          state_nxt = epi_pkg::S_SR_CMP;
        end
      end
      epi_pkg::S_SR_CMP: begin
        ctl.op    = epi_pkg::OP_SR_CMP;
        state_nxt = epi_pkg::S_SR_RD;
      end
      epi_pkg::S_EV_RDA: begin
        ctl.op    = epi_pkg::OP_EV_RDA;
        state_nxt = epi_pkg::S_EV_CAPA;
      end
      epi_pkg::S_EV_CAPA: begin
        ctl.op    = epi_pkg::OP_EV_CAPA;
        state_nxt = stat.endpt ? epi_pkg::S_EV_END : epi_pkg::S_EV_CAPB;
      end
      epi_pkg::S_EV_CAPB: begin
        ctl.op    = epi_pkg::OP_EV_CAPB;
        state_nxt = stat.exp_mode ? epi_pkg::S_EV_CLS : epi_pkg::S_MUL1;
      end
      epi_pkg::S_EV_CLS: begin
        ctl.op     = epi_pkg::OP_EV_CLS;
        log2nd_nxt = 1'b0;
        state_nxt  = stat.cls_hit ? epi_pkg::S_EV_END : epi_pkg::S_LOG_INIT;
      end
      epi_pkg::S_LOG_INIT: begin
        ctl.op    = epi_pkg::OP_LOG_INIT;
        state_nxt = epi_pkg::S_LOG_STEP;
      end
      epi_pkg::S_LOG_STEP: begin
        ctl.op = epi_pkg::OP_LOG_STEP;
        if (stat.it24_last) begin
          state_nxt = epi_pkg::S_LOG_DONE;
        end
      end
      epi_pkg::S_LOG_DONE: begin
        ctl.op     = epi_pkg::OP_LOG_DONE;
        log2nd_nxt = 1'b1;
        state_nxt  = log2nd_r ? epi_pkg::S_MUL1 : epi_pkg::S_LOG_INIT;
      end
      epi_pkg::S_MUL1: begin
        ctl.op    = epi_pkg::OP_MUL1;
        state_nxt = epi_pkg::S_MUL2;
      end
      epi_pkg::S_MUL2: begin
        ctl.op    = epi_pkg::OP_MUL2;
        state_nxt = epi_pkg::S_MUL3;
      end
      epi_pkg::S_MUL3: begin
        ctl.op    = epi_pkg::OP_MUL3;
        state_nxt = epi_pkg::S_DIV_INIT;
      end
      epi_pkg::S_DIV_INIT: begin
        ctl.op    = epi_pkg::OP_DIV_INIT;
        state_nxt = epi_pkg::S_DIV_STEP;
      end
      epi_pkg::S_DIV_STEP: begin
        ctl.op = epi_pkg::OP_DIV_STEP;
        if (stat.it30_last) begin
          state_nxt = epi_pkg::S_DIV_END;
        end
      end
      epi_pkg::S_DIV_END: begin
        if (stat.exp_mode) begin
          ctl.op    = epi_pkg::OP_EXP_INIT;
          state_nxt = epi_pkg::S_EXP_STEP;
        end else begin
          ctl.op    = epi_pkg::OP_RES_QUO;
          state_nxt = epi_pkg::S_EV_END;
        end
      end
      epi_pkg::S_EXP_STEP: begin
        ctl.op = epi_pkg::OP_EXP_STEP;
        if (stat.it24_last) begin
          state_nxt = epi_pkg::S_EXP_FIN;
        end
      end
      epi_pkg::S_EXP_FIN: begin
        ctl.op    = epi_pkg::OP_EXP_FIN;
        state_nxt = epi_pkg::S_EV_END;
      end
      epi_pkg::S_EV_END: begin
        state_nxt = (stat.cmd == epi_pkg::CMD_TRUNC) ? epi_pkg::S_TR_CUT : epi_pkg::S_FIN;
      end
      epi_pkg::S_TR_START: begin
        ctl.op    = epi_pkg::OP_SR_INIT;
        ctl.smode = epi_pkg::SK_FIRST;
        srch_nxt  = epi_pkg::SK_FIRST;
        state_nxt = epi_pkg::S_SR_RD;
      end
      epi_pkg::S_TR_FIRST: begin
        ctl.op    = epi_pkg::OP_TR_FIRST;
        ctl.smode = epi_pkg::SK_AFTER;
        srch_nxt  = epi_pkg::SK_AFTER;
        state_nxt = epi_pkg::S_SR_RD;
      end
      epi_pkg::S_TR_AFTER: begin
        ctl.op    = epi_pkg::OP_TR_AFTER;
        state_nxt = stat.need_now ? epi_pkg::S_EV_START : epi_pkg::S_TR_CUT;
      end
      epi_pkg::S_TR_CUT: begin
        ctl.op    = epi_pkg::OP_TR_CUT;
        state_nxt = stat.need ? epi_pkg::S_AP_RD : epi_pkg::S_FIN;
      end
      epi_pkg::S_FIN: begin
        ctl.op    = epi_pkg::OP_FIN;
        state_nxt = epi_pkg::S_IDLE;
      end
      default: state_nxt = epi_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/epi_datapath.sv -----
// ----------------------------------------------------------------------------
// epi_datapath
// Point tables, search registers, shared multiplier, divider, log and exp.
// ----------------------------------------------------------------------------
`include "envelope_point_interpolator_macros.svh"

module epi_datapath #(
  parameter int MAX_POINTS = epi_pkg::MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  epi_pkg::dp_ctl_t  ctl,
  output epi_pkg::dp_stat_t stat,
  input  logic [1:0]        in_cmd,
  input  logic [31:0]       in_sample_time,
  input  logic [23:0]       in_point_value,
  input  logic              in_left_limit,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [23:0]       cfg_data,
  output logic              out_valid,
  output logic [23:0]       out_gain,
  output logic [1:0]        out_status
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int IW = $clog2(MAX_POINTS);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
  localparam epi_pkg::exp_tab_t EXP_TAB = epi_pkg::exp_tab_gen();

  logic                exp_r;
  logic [23:0]         dflt_r;
  logic [15:0]         step_r;
  logic [CW-1:0]       cnt_r;
  logic [31:0]         trk_r;
  logic                ov_r;
  epi_pkg::cmd_t       cmd_r;
  epi_pkg::status_t    st_r, og_st_r;
  epi_pkg::srch_kind_t mode_r;
  logic [31:0]         time_r, tlo_r, d_r, dt_r, rem_r, acc_r;
  logic                left_r, need_r;
  logic [23:0]         res_r, og_r, frac_r;
  logic [CW-1:0]       lo_r, hi_r, first_r, after_r;
  logic [28:0]         a_r, b_r;
  logic [63:0]         p_r;
  logic [61:0]         num_r;
  logic [29:0]         q_r, x_r;
  logic [4:0]          iter_r, e_r;
  logic [30:0]         m_r;

  logic [CW-1:0] mid;
  logic [IW-1:0] raddr, waddr;
  logic [31:0]   rd_t;
  logic [23:0]   rd_g;
  logic          pred, t_we, g_we;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   prod;
  logic [33:0]   sq;
  logic [4:0]    e_c, ipc;
  logic [30:0]   m_init;
  logic [32:0]   trial;
  logic          ge;
  logic [54:0]   sh;
  logic          ap_dec, ap_ovw, ap_full;
  logic [CW:0]   first_p1;

  assign mid = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);

  always_comb begin
    unique case (ctl.op)
      epi_pkg::OP_SR_RD:   raddr = IW'(mid);
      epi_pkg::OP_EV_RDA:  raddr = (lo_r == '0) ? '0 : IW'(lo_r - 1'b1);
      epi_pkg::OP_EV_CAPA: raddr = IW'(lo_r);
      epi_pkg::OP_AP_RD:   raddr = IW'(cnt_r - 1'b1);
      epi_pkg::OP_AP_C1:   raddr = IW'(cnt_r - 2'd2);
      default:             raddr = '0;
    endcase
  end

  always_comb begin
    unique case (mode_r)
      epi_pkg::SK_FIRST: pred = ({1'b0, rd_t, 1'b0} + 34'(step_r)) < {1'b0, time_r, 1'b0};
      epi_pkg::SK_AFTER: pred = {1'b0, rd_t, 1'b0} <= ({1'b0, time_r, 1'b0} + 34'(step_r));
      default:           pred = left_r ? (rd_t < time_r) : (rd_t <= time_r);
    endcase
  end

  always_comb begin
    unique case (ctl.op)
      epi_pkg::OP_MUL1: begin
        mul_a = 32'(a_r);
        mul_b = dt_r - d_r;
      end
      epi_pkg::OP_MUL2: begin
        mul_a = 32'(b_r);
        mul_b = d_r;
      end
      epi_pkg::OP_LOG_STEP: begin
        mul_a = 32'(m_r);
        mul_b = 32'(m_r);
      end
      epi_pkg::OP_EXP_STEP: begin
        mul_a = acc_r;
        mul_b = EXP_TAB[iter_r];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign sq   = prod[63:30];

  always_comb begin
    e_c = '0;
    for (int i = 0; i < 24; i++) begin
      if (a_r[i]) begin
        e_c = 5'(i);
      end
    end
  end

  assign m_init = 31'({7'd0, a_r[23:0]} << (5'd30 - e_c));
  assign trial  = {rem_r, q_r[29]};
  assign ge     = trial >= {1'b0, dt_r};
  assign ipc    = (x_r[29:24] > 6'd23) ? 5'd23 : x_r[28:24];
  assign sh     = 55'(acc_r) << ipc;

  assign ap_dec   = (cnt_r != '0) && (time_r < d_r);
  assign ap_ovw   = (cnt_r >= CW'(2)) && (tlo_r == time_r) && (d_r == time_r);
  assign ap_full  = (cnt_r == CNT_MAX);
  assign first_p1 = {1'b0, first_r} + 1'b1;

  assign t_we  = (ctl.op == epi_pkg::OP_AP_DO) && !ap_dec && !ap_ovw && !ap_full;
  assign g_we  = (ctl.op == epi_pkg::OP_AP_DO) && !ap_dec && (ap_ovw || !ap_full);
  assign waddr = ap_ovw ? IW'(cnt_r - 1'b1) : IW'(cnt_r);

  epi_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_times (
    .clk(clk), .we(t_we), .waddr(waddr), .wdata(time_r), .raddr(raddr), .rdata(rd_t)
  );

  epi_ram #(.WIDTH(24), .DEPTH(MAX_POINTS)) u_gains (
    .clk(clk), .we(g_we), .waddr(waddr), .wdata(res_r), .raddr(raddr), .rdata(rd_g)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r  <= 1'b0;
      dflt_r <= 24'd1048576;
      step_r <= 16'd256;
      cnt_r  <= '0;
      trk_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= (ctl.op == epi_pkg::OP_FIN);
      if (cfg_we) begin
        unique case (cfg_index)
          epi_pkg::CFG_EXP:  exp_r  <= cfg_data[0];
          epi_pkg::CFG_DFLT: dflt_r <= cfg_data;
          epi_pkg::CFG_STEP: step_r <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ctl.op == epi_pkg::OP_TR_CUT) begin
        trk_r <= time_r;
        cnt_r <= (first_p1 < {1'b0, after_r}) ? CW'(first_p1) : after_r;
      end else if (t_we) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      epi_pkg::OP_LOAD: begin
        cmd_r  <= epi_pkg::cmd_t'(in_cmd);
        time_r <= in_sample_time;
        res_r  <= in_point_value;
        left_r <= in_left_limit && (in_cmd == epi_pkg::CMD_EVAL);
        st_r   <= epi_pkg::ST_OK;
      end
      epi_pkg::OP_SR_INIT: begin
        lo_r   <= '0;
        hi_r   <= cnt_r;
        mode_r <= ctl.smode;
      end
      epi_pkg::OP_SR_CMP: begin
        if (pred) begin
          lo_r <= mid + 1'b1;
        end else begin
          hi_r <= mid;
        end
      end
      epi_pkg::OP_EV_CAPA: begin
        tlo_r <= rd_t;
        a_r   <= 29'(rd_g);
        res_r <= rd_g;
      end
      epi_pkg::OP_EV_CAPB: begin
        b_r  <= 29'(rd_g);
        dt_r <= rd_t - tlo_r;
        d_r  <= time_r - tlo_r;
      end
      epi_pkg::OP_EV_CLS: begin
        res_r <= (d_r == '0) ? a_r[23:0] : (d_r == dt_r) ? b_r[23:0] : 24'd0;
      end
      epi_pkg::OP_LOG_INIT: begin
        m_r    <= m_init;
        e_r    <= e_c;
        frac_r <= '0;
        iter_r <= '0;
      end
      epi_pkg::OP_LOG_STEP: begin
        m_r    <= sq[31] ? sq[31:1] : sq[30:0];
        frac_r <= {frac_r[22:0], sq[31]};
        iter_r <= iter_r + 1'b1;
      end
      epi_pkg::OP_LOG_DONE: begin
        a_r <= b_r;
        b_r <= {e_r, frac_r};
      end
      epi_pkg::OP_MUL1: p_r <= prod;
      epi_pkg::OP_MUL2: begin
        num_r <= p_r[61:0];
        p_r   <= prod;
      end
      epi_pkg::OP_MUL3: num_r <= num_r + p_r[61:0] + 62'(dt_r >> 1);
      epi_pkg::OP_DIV_INIT: begin
        rem_r  <= num_r[61:30];
        q_r    <= num_r[29:0];
        iter_r <= '0;
      end
      epi_pkg::OP_DIV_STEP: begin
        rem_r  <= ge ? 32'(trial - {1'b0, dt_r}) : trial[31:0];
        q_r    <= {q_r[28:0], ge};
        iter_r <= iter_r + 1'b1;
      end
      epi_pkg::OP_RES_QUO: res_r <= epi_pkg::sat24({2'b00, q_r});
      epi_pkg::OP_EXP_INIT: begin
        x_r    <= q_r;
        acc_r  <= 32'd1 << 30;
        iter_r <= '0;
      end
      epi_pkg::OP_EXP_STEP: begin
        if (x_r[5'd23 - iter_r]) begin
          acc_r <= 32'((prod + (64'd1 << 29)) >> 30);
        end
        iter_r <= iter_r + 1'b1;
      end
      epi_pkg::OP_EXP_FIN: res_r <= epi_pkg::sat24(32'((sh + (55'd1 << 29)) >> 30));
      epi_pkg::OP_RES_DFLT: res_r <= dflt_r;
      epi_pkg::OP_TR_FIRST: begin
        first_r <= lo_r;
        hi_r    <= cnt_r;
        mode_r  <= ctl.smode;
      end
      epi_pkg::OP_TR_AFTER: begin
        after_r <= lo_r;
        need_r  <= stat.need_now;
      end
      epi_pkg::OP_AP_C1: d_r <= rd_t;
      epi_pkg::OP_AP_C2: tlo_r <= rd_t;
      epi_pkg::OP_AP_DO: begin
        if (ap_dec) begin
          st_r <= epi_pkg::ST_DEC;
        end else if (!ap_ovw && ap_full) begin
          st_r <= epi_pkg::ST_FULL;
        end
      end
      epi_pkg::OP_FIN: begin
        og_r    <= (cmd_r == epi_pkg::CMD_EVAL) ? res_r : 24'd0;
        og_st_r <= st_r;
      end
      default: ;
    endcase
  end

  assign stat.cmd       = cmd_r;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.srch_done = (lo_r == hi_r);
  assign stat.endpt     = (lo_r == '0) || (lo_r == cnt_r);
  assign stat.exp_mode  = exp_r;
  assign stat.cls_hit   = (d_r == '0) || (d_r == dt_r) || (a_r == '0) || (b_r == '0);
  assign stat.it24_last = (iter_r == 5'd23);
  assign stat.it30_last = (iter_r == 5'd29);
  assign stat.need_now  = (first_r == lo_r) && (time_r < trk_r);
  assign stat.need      = need_r;

  assign out_valid  = ov_r;
  assign out_gain   = og_r;
  assign out_status = og_st_r;

  `EPI_ASSERT_IMPLY(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CNT_MAX, "point count over capacity")
  `EPI_ASSERT_NEXT(a_one_strobe, clk, rst_n, ov_r, !ov_r, "result strobe longer than one cycle")
  `EPI_ASSERT_IMPLY(a_srch_order, clk, rst_n, ctl.op == epi_pkg::OP_SR_CMP, lo_r < hi_r, "search window empty on compare")
  `EPI_ASSERT_IMPLY(a_wr_excl, clk, rst_n, t_we, g_we, "time written without gain")

endmodule

// ----- rtl/envelope_point_interpolator.sv -----
// ----------------------------------------------------------------------------
// envelope_point_interpolator
// Piecewise linear or geometric gain envelope over a table of time points.
// ----------------------------------------------------------------------------
//   channel  ports                                         handshake
//   input    in_cmd in_sample_time in_point_value           start & !busy
//            in_left_limit
//   result   out_gain out_status                           out_valid, 1 cycle
//   config   cfg_index cfg_data                            cfg_we
//
// One transaction at a time. Truncate: two binary searches (a read and a
// compare step per probe, up to log2(MAX_POINTS)+1 probes each), plus the
// evaluate steps and 4 append steps when an end point is added. Evaluate:
// search plus 30 divider steps in linear mode; geometric mode adds two
// 24-step log passes and a 24-step exp pass on the one shared multiplier.
// Synchronous reset empties the table. Results cannot be stalled; busy drops
// in the cycle out_valid is high.
module envelope_point_interpolator #(
  parameter int MAX_POINTS = epi_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_sample_time,
  input  logic [23:0] in_point_value,
  input  logic        in_left_limit,
  output logic        out_valid,
  output logic [23:0] out_gain,
  output logic [1:0]  out_status,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  epi_pkg::dp_ctl_t  ctl;
  epi_pkg::dp_stat_t stat;

  epi_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .ctl   (ctl),
    .stat  (stat)
  );

  epi_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .stat           (stat),
    .in_cmd         (in_cmd),
    .in_sample_time (in_sample_time),
    .in_point_value (in_point_value),
    .in_left_limit  (in_left_limit),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_gain       (out_gain),
    .out_status     (out_status)
  );

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: envelope point interpolator testbench
// Drives append, evaluate, truncate and no-op transactions under several register
// settings, predicts every result with a bit-accurate envelope table model and
// checks each strobed result, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  typedef struct {
    epi_pkg::cmd_t cmd;
    logic [31:0]   t;
    logic [23:0]   v;
    logic          left;
  } env_item_t;

  typedef struct {
    logic [23:0]      gain;
    epi_pkg::status_t status;
  } env_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_cmd = 2'd0;
  logic [31:0] in_sample_time = 32'd0;
  logic [23:0] in_point_value = 24'd0;
  logic        in_left_limit = 1'b0;
  logic        out_valid;
  logic [23:0] out_gain;
  logic [1:0]  out_status;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [23:0] cfg_data = 24'd0;

  envelope_point_interpolator u_top (.*);

  env_item_t   pending_q[$];
  env_result_t gain_exp_q[$];
  int          errors = 0;
  bit          no_idle = 1'b0;

  // envelope table model
  logic [31:0] env_t [64];
  logic [23:0] env_g [64];
  int unsigned env_n = 0;
  logic [31:0] env_len = 32'd0;
  logic        m_exp = 1'b0;
  logic [23:0] m_dflt = 24'd1048576;
  logic [15:0] m_step = 16'd256;

  function automatic longint unsigned sqrt_floor(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned log2_fix(longint unsigned x);
    longint unsigned e, m, frac;
    e = 0;
    frac = 0;
    while (e < 23 && (x >> (e + 1)) != 0) e++;
    m = x << (30 - e);
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        frac |= 64'd1 << i;
        m = m >> 1;
      end
    end
    return (e << 24) | frac;
  endfunction

  function automatic longint unsigned exp2_fix(longint unsigned x);
    longint unsigned ip, f, acc, r;
    ip = x >> 24;
    f = x & 64'hFF_FFFF;
    acc = 64'd1 << 30;
    r = 64'd2 << 30;
    for (int k = 1; k <= 24; k++) begin
      r = sqrt_floor(r << 30);
      if ((f >> (24 - k)) & 1) acc = (acc * r + (64'd1 << 29)) >> 30;
    end
    if (ip > 23) ip = 23;
    return ((acc << ip) + (64'd1 << 29)) >> 30;
  endfunction

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned d, longint unsigned dt);
    return (a * (dt - d) + b * d + dt / 2) / dt;
  endfunction

  function logic [23:0] env_gain_at(logic [31:0] t, logic left);
    longint unsigned lo, dt, d, gp, gn, v;
    if (env_n == 0) return m_dflt;
    if (left ? t <= env_t[0] : t < env_t[0]) return env_g[0];
    if (left ? t > env_t[env_n-1] : t >= env_t[env_n-1]) return env_g[env_n-1];
    lo = 0;
    while (lo + 1 < env_n && (left ? env_t[lo+1] < t : env_t[lo+1] <= t)) lo++;
    if (lo + 1 >= env_n) return env_g[env_n-1];
    gp = env_g[lo];
    gn = env_g[lo+1];
    dt = env_t[lo+1] - env_t[lo];
    if (dt == 0) return gn;
    d = t - env_t[lo];
    if (!m_exp) begin
      v = blend(gp, gn, d, dt);
    end else begin
      if (d == 0) return gp;
      if (d == dt) return gn;
      if (gp == 0 || gn == 0) return 24'd0;
      v = exp2_fix(blend(log2_fix(gp), log2_fix(gn), d, dt));
    end
    return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  function epi_pkg::status_t env_append(logic [31:0] t, logic [23:0] g);
    if (env_n > 0 && t < env_t[env_n-1]) return epi_pkg::ST_DEC;
    if (env_n >= 2 && env_t[env_n-2] == t && env_t[env_n-1] == t) begin
      env_g[env_n-1] = g;
      return epi_pkg::ST_OK;
    end
    if (env_n >= 64) return epi_pkg::ST_FULL;
    env_t[env_n] = t;
    env_g[env_n] = g;
    env_n++;
    return epi_pkg::ST_OK;
  endfunction

  function epi_pkg::status_t env_truncate(logic [31:0] len);
    int unsigned first, after;
    longint unsigned two_len;
    logic need;
    logic [23:0] v;
    first = 0;
    two_len = 64'(len) * 2;
    v = 24'd0;
    while (first < env_n && 64'(env_t[first]) * 2 + m_step < two_len) first++;
    after = first;
    while (after < env_n && 64'(env_t[after]) * 2 <= two_len + m_step) after++;
    need = (first == after) && (len < env_len);
    if (need) v = env_gain_at(len, 1'b0);
    env_len = len;
    env_n = (first + 1 < after) ? first + 1 : after;
    if (need) return env_append(len, v);
    return epi_pkg::ST_OK;
  endfunction

  function env_result_t env_predict(env_item_t it);
    env_result_t r;
    r.gain = 24'd0;
    r.status = epi_pkg::ST_OK;
    case (it.cmd)
      epi_pkg::CMD_APPEND: r.status = env_append(it.t, it.v);
      epi_pkg::CMD_EVAL:   r.gain = env_gain_at(it.t, it.left);
      epi_pkg::CMD_TRUNC:  r.status = env_truncate(it.t);
      default:             ;
    endcase
    return r;
  endfunction

  initial forever #1 clk = ~clk;

  // driver
  always @(posedge clk) begin : drive
    env_item_t it;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        it.cmd = epi_pkg::cmd_t'(in_cmd);
        it.t = in_sample_time;
        it.v = in_point_value;
        it.left = in_left_limit;
        gain_exp_q = {gain_exp_q, env_predict(it)};
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && (no_idle || $urandom_range(99) >= 13)) begin
          it = pending_q.pop_front();
          start <= 1'b1;
          in_cmd <= it.cmd;
          in_sample_time <= it.t;
          in_point_value <= it.v;
          in_left_limit <= it.left;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    env_result_t e;
    if (rst_n && out_valid) begin
      if (gain_exp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result gain=%h status=%0d", $time, out_gain, out_status);
      end else begin
        e = gain_exp_q.pop_front();
        if (out_gain !== e.gain) begin
          errors++;
          $display("%0t: gain expected %h actual %h", $time, e.gain, out_gain);
        end
        if (out_status !== e.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
        end
      end
    end
  end

  task automatic add(epi_pkg::cmd_t c, logic [31:0] t, logic [23:0] v = 24'd0,
                     logic l = 1'b0);
    env_item_t it;
    it.cmd = c;
    it.t = t;
    it.v = v;
    it.left = l;
    pending_q = {pending_q, it};
  endtask

  task automatic write_reg(epi_pkg::cfg_idx_t idx, logic [23:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      epi_pkg::CFG_EXP:  m_exp = data[0];
      epi_pkg::CFG_DFLT: m_dflt = data;
      epi_pkg::CFG_STEP: m_step = data[15:0];
      default:           ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || start || gain_exp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic gen_random(int count);
    logic [31:0] base, cur, t;
    int r, k;
    base = $urandom_range(5000);
    cur = base;
    k = 0;
    while (k < count) begin
      r = $urandom_range(99);
      if (r < 40) begin
        r = $urandom_range(99);
        if (r < 15) t = cur;
        else if (r < 20) t = cur - $urandom_range(1, 300);
        else if (r < 23) t = $urandom();
        else t = cur + $urandom_range(1, 4000);
        if (t > cur) cur = t;
        add(epi_pkg::CMD_APPEND, t,
            ($urandom_range(9) == 0) ? 24'($urandom_range(1)) * 24'hFF_FFFF
                                     : 24'($urandom()), $urandom_range(1));
      end else if (r < 80) begin
        if ($urandom_range(9) == 0) t = $urandom();
        else t = base + $urandom_range(0, cur - base + 1000) - 500;
        add(epi_pkg::CMD_EVAL, t, 24'($urandom()), $urandom_range(1));
      end else if (r < 92) begin
        t = base + $urandom_range(0, cur - base + 600) - 300;
        cur = t;
        add(epi_pkg::CMD_TRUNC, t, 24'($urandom()), $urandom_range(1));
      end else if (r < 95) begin
        add(epi_pkg::CMD_NOP, $urandom(), 24'($urandom()), $urandom_range(1));
      end else if (r < 97) begin
        for (int i = 0; i < 68; i++) begin
          cur = cur + $urandom_range(0, 50);
          add(epi_pkg::CMD_APPEND, cur, 24'($urandom()));
        end
        k += 67;
      end else begin
        base = $urandom_range(3) == 0 ? $urandom() >> 1 : 32'd0;
        cur = base;
        add(epi_pkg::CMD_TRUNC, base, 24'($urandom()), $urandom_range(1));
      end
      k++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add(epi_pkg::CMD_EVAL, 32'd1000, 24'd0, 1'b1);
    add(epi_pkg::CMD_APPEND, 32'd0, 24'd0);
    add(epi_pkg::CMD_APPEND, 32'd1000, 24'hFF_FFFF);
    add(epi_pkg::CMD_APPEND, 32'd1000, 24'd5);
    add(epi_pkg::CMD_APPEND, 32'd1000, 24'd7);
    add(epi_pkg::CMD_APPEND, 32'd500, 24'd9);
    add(epi_pkg::CMD_APPEND, 32'd3000, 24'h10_0000);
    add(epi_pkg::CMD_EVAL, 32'd0, 24'd0, 1'b1);
    add(epi_pkg::CMD_EVAL, 32'd1000, 24'd0, 1'b1);
    add(epi_pkg::CMD_EVAL, 32'd1000, 24'd0, 1'b0);
    add(epi_pkg::CMD_EVAL, 32'd600, 24'd0, 1'b0);
    add(epi_pkg::CMD_EVAL, 32'hFFFF_FFFF, 24'd0, 1'b1);
    add(epi_pkg::CMD_TRUNC, 32'd2000, 24'd0);
    add(epi_pkg::CMD_EVAL, 32'd1999, 24'd0, 1'b0);
    add(epi_pkg::CMD_TRUNC, 32'd1127, 24'd0);
    add(epi_pkg::CMD_NOP, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b1);
    add(epi_pkg::CMD_TRUNC, 32'd0, 24'd0);
    add(epi_pkg::CMD_EVAL, 32'd77, 24'd0, 1'b0);
    drain();

    no_idle = 1'b1;
    gen_random(200);
    drain();
    no_idle = 1'b0;

    write_reg(epi_pkg::CFG_EXP, 24'd1);
    add(epi_pkg::CMD_TRUNC, 32'd0);
    add(epi_pkg::CMD_APPEND, 32'd100, 24'd0);
    add(epi_pkg::CMD_APPEND, 32'd200, 24'h10_0000);
    add(epi_pkg::CMD_APPEND, 32'd300, 24'hFF_FFFF);
    add(epi_pkg::CMD_EVAL, 32'd150);
    add(epi_pkg::CMD_EVAL, 32'd250);
    add(epi_pkg::CMD_EVAL, 32'd200, 24'd0, 1'b1);
    gen_random(220);
    drain();

    write_reg(epi_pkg::CFG_DFLT, 24'd0);
    write_reg(epi_pkg::CFG_STEP, 24'd1);
    gen_random(220);
    drain();

    write_reg(epi_pkg::CFG_EXP, 24'd0);
    write_reg(epi_pkg::CFG_DFLT, 24'hFF_FFFF);
    write_reg(epi_pkg::CFG_STEP, 24'hFFFF);
    gen_random(220);
    drain();

    write_reg(epi_pkg::CFG_EXP, 24'd1);
    write_reg(epi_pkg::CFG_STEP, 24'd1000);
    gen_random(220);
    drain();

    write_reg(epi_pkg::CFG_EXP, 24'd0);
    write_reg(epi_pkg::CFG_DFLT, 24'h12_3456);
    write_reg(epi_pkg::CFG_STEP, 24'd3);
    gen_random(220);
    drain();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
